// ===== src/msra_pkg.sv =====
// ----------------------------------------------------------------------------
// msra_pkg: shared types and codes of the sample ring averager
// Field widths, request and status codes, and the controller state type.
// ----------------------------------------------------------------------------
package msra_pkg;

    localparam int SAMPLE_W = 10;
    localparam int CHAN_W   = 4;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = 10'h3FF;

    // Request kinds carried in the input tuser.
    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Result status carried in the output tuser.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAIN,
        S_LAST,
        S_DIV,
        S_EMIT
    } msra_state_t;

endpackage

// ===== src/msra_div.sv =====
// ----------------------------------------------------------------------------
// msra_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msra_div #(
    parameter int DW = 13,
    parameter int VW = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int SCW = (DW > 1) ? $clog2(DW) : 1;

    logic [VW-1:0]  rem_reg, rem_next;
    logic [DW-1:0]  quo_reg, quo_next;
    logic [VW-1:0]  dvs_reg, dvs_next;
    logic [SCW-1:0] step_reg, step_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;

    logic [VW:0]    trial;
    logic           fits;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            step_next = SCW'(DW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? VW'(trial - {1'b0, dvs_reg}) : VW'(trial);
            quo_next = {quo_reg[DW-2:0], fits};
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        step_reg <= step_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/multichannel_sample_ring_averager_unit.sv =====
// ----------------------------------------------------------------------------
// multichannel_sample_ring_averager_unit: per-channel sample rings with
// drain-and-average reads.
// Stores converter samples per channel and returns the mean of unread ones.
// ----------------------------------------------------------------------------
// Usage.
// Words enter on the s_axis channel. The tuser bit selects the request:
// a store word writes its sample into the ring of its channel, and a read
// word drains all unread samples of its channel and returns one result word
// on the m_axis channel with their truncated mean and a status flag. When no
// sample is unread, the read returns the most recent sample of the channel
// (zero if the channel was never written). A channel at or beyond CHANNELS is
// ignored on a store and answered with status set and a zero average on a
// read. Stores never produce a result word.
// Timing. A store leaves the input ready, so the next word is taken right
// after it. A read that drains samples does one memory read per sample,
// then one quotient bit per cycle in the shared divider. Only one read is
// in flight at a time.
// Reset clears all pointers and the per-channel written flags at once; the
// sample memory itself needs no clearing pass. A result waits in the output
// register while the receiver stalls; a further store is still taken, and a
// further read finishes its work and then holds until that register frees.
// ----------------------------------------------------------------------------
module multichannel_sample_ring_averager_unit #(
    parameter int CHANNELS = 6,
    parameter int DEPTH    = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input word.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [3:0] channel, [13:4] sample, rest zero
    input  logic [0:0]  s_axis_tuser,   // [0] req_type
    // Result word.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] average, rest zero
    output logic [0:0]  m_axis_tuser    // [0] status
);

    import msra_pkg::*;

    // Pointer, count and sum widths. A drain covers at most DEPTH-1 samples.
    localparam int PW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH);
    localparam int SW  = SAMPLE_W + CW;
    localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW  = $clog2(CHANNELS * DEPTH);
    localparam int MEM_DEPTH = CHANNELS * DEPTH;

    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] slot_addr(input logic [CIW-1:0] c,
                                                input logic [PW-1:0]  p);
        return AW'(c) * AW'(DEPTH) + AW'(p);
    endfunction

    // Input word fields.
    logic                in_req;
    logic [CHAN_W-1:0]   in_chan;
    logic [SAMPLE_W-1:0] in_sample;
    logic                in_ok_chan;
    logic [CIW-1:0]      in_idx;
    logic                in_fire;

    assign in_req     = s_axis_tuser[0];
    assign in_chan    = s_axis_tdata[3:0];
    assign in_sample  = s_axis_tdata[13:4] & SAMPLE_MASK;
    assign in_ok_chan = ({1'b0, in_chan} < 5'(CHANNELS));
    assign in_idx     = CIW'(in_chan);
    assign in_fire    = s_axis_tvalid && s_axis_tready;

    // Sample memory, one row of DEPTH slots per channel.
    logic [SAMPLE_W-1:0] mem [MEM_DEPTH];
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= in_sample;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Per-channel pointers and written flags.
    logic [PW-1:0]       wp_reg [CHANNELS];
    logic [PW-1:0]       rp_reg [CHANNELS];
    logic [CHANNELS-1:0] written_reg;
    logic                wp_we;
    logic                rp_we;

    // Controller registers.
    msra_state_t         state_reg, state_next;
    logic [CIW-1:0]      ch_reg, ch_next;
    logic [PW-1:0]       cur_reg, cur_next;
    logic [PW-1:0]       end_reg, end_next;
    logic [SW-1:0]       sum_reg, sum_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0] res_avg_reg, res_avg_next;
    logic                res_bad_reg, res_bad_next;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_avg_reg, out_avg_next;
    logic                out_bad_reg, out_bad_next;

    // Divider.
    logic                div_start;
    logic [SW-1:0]       div_dividend;
    logic [CW-1:0]       div_divisor;
    logic                div_done;
    logic [SW-1:0]       div_quotient;

    logic [PW-1:0]       in_wp;
    logic [PW-1:0]       in_rp;
    logic [PW-1:0]       in_last;
    logic [SW-1:0]       sum_add;
    logic [CW-1:0]       cnt_add;

    assign in_wp   = wp_reg[in_idx];
    assign in_rp   = rp_reg[in_idx];
    assign in_last = (in_wp == '0) ? PTR_LAST : in_wp - 1'b1;
    assign sum_add = sum_reg + SW'(rd_data_reg);
    assign cnt_add = cnt_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        cur_next       = cur_reg;
        end_next       = end_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        res_avg_next   = res_avg_reg;
        res_bad_next   = res_bad_reg;
        out_avg_next   = out_avg_reg;
        out_bad_next   = out_bad_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        mem_we         = 1'b0;
        mem_waddr      = slot_addr(in_idx, in_wp);
        mem_re         = 1'b0;
        mem_raddr      = slot_addr(in_idx, in_rp);
        wp_we          = 1'b0;
        rp_we          = 1'b0;
        div_start      = 1'b0;
        div_dividend   = sum_add;
        div_divisor    = cnt_add;
        s_axis_tready  = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ch_next = in_idx;
                    if (in_req == REQ_STORE)
                    begin
                        // Stores to a channel out of range are dropped.
                        mem_we = in_ok_chan;
                        wp_we  = in_ok_chan;
                    end
                    else if (!in_ok_chan)
                    begin
                        res_avg_next = '0;
                        res_bad_next = STATUS_BAD;
                        state_next   = S_EMIT;
                    end
                    else if (in_rp == in_wp)
                    begin
                        // Nothing unread: answer with the most recent sample.
                        res_bad_next = STATUS_OK;
                        if (written_reg[in_idx])
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = slot_addr(in_idx, in_last);
                            state_next = S_LAST;
                        end
                        else
                        begin
                            res_avg_next = '0;
                            state_next   = S_EMIT;
                        end
                    end
                    else
                    begin
                        mem_re       = 1'b1;
                        cur_next     = ring_next(in_rp);
                        end_next     = in_wp;
                        sum_next     = '0;
                        cnt_next     = '0;
                        res_bad_next = STATUS_OK;
                        state_next   = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                // Read data of the previous slot arrives now.
                sum_next = sum_add;
                cnt_next = cnt_add;
                if (cur_reg == end_reg)
                begin
                    rp_we      = 1'b1;
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = slot_addr(ch_reg, cur_reg);
                    cur_next   = ring_next(cur_reg);
                end
            end
            S_LAST:
            begin
                res_avg_next = rd_data_reg;
                state_next   = S_EMIT;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_avg_next = div_quotient[SAMPLE_W-1:0];
                    state_next   = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_avg_next   = res_avg_reg;
                    out_bad_next   = res_bad_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                wp_reg[c] <= '0;
                rp_reg[c] <= '0;
            end
            written_reg <= '0;
        end
        else
        begin
            if (wp_we)
            begin
                wp_reg[in_idx]      <= ring_next(in_wp);
                written_reg[in_idx] <= 1'b1;
            end
            if (rp_we)
            begin
                rp_reg[ch_reg] <= end_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg      <= ch_next;
        cur_reg     <= cur_next;
        end_reg     <= end_next;
        sum_reg     <= sum_next;
        cnt_reg     <= cnt_next;
        res_avg_reg <= res_avg_next;
        res_bad_reg <= res_bad_next;
        out_avg_reg <= out_avg_next;
        out_bad_reg <= out_bad_next;
    end

    msra_div #(
        .DW (SW),
        .VW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_avg_reg};
    assign m_axis_tuser  = out_bad_reg;

endmodule

// ===== src/msra_checker.sv =====
// ----------------------------------------------------------------------------
// msra_checker: port-level checks of the sample ring averager
// Watches the stream ports and flags behavior the block must never show.
// ----------------------------------------------------------------------------
module msra_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    import msra_pkg::*;

    // A stalled result word holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

    // A bad-channel result carries a zero average.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] == STATUS_BAD |-> m_axis_tdata == 16'h0000)
    else $error("bad-channel result with nonzero average");

    // A store word leaves the input ready in the cycle after it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == REQ_STORE |=> s_axis_tready)
    else $error("input not ready after a store word");

    // A read word always occupies the block for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == REQ_READ |=> !s_axis_tready)
    else $error("input ready right after a read word");

    // The average never exceeds ten bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:10] == 6'b0)
    else $error("result padding bits set");

endmodule

bind multichannel_sample_ring_averager_unit msra_checker u_msra_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the multichannel sample ring averager
// Drives store and read words into the stream input and compares every
// result word with a cycle-free model of the channel rings kept here.
// Directed tests come first, then a long run of random store bursts
// each closed by a read, mixed with random noise words.
// ----------------------------------------------------------------------------
module tb_top;

    import msra_pkg::*;

    localparam int NUM_CH      = 6;
    localparam int CH_W        = $clog2(NUM_CH);
    localparam int RING_DEPTH  = 8;
    localparam int PTR_W       = $clog2(RING_DEPTH);
    localparam int IDLE_PCT    = 22;
    localparam int RANDOM_ITEMS = 1350;
    localparam int CALM_ITEMS  = 300;
    localparam int DRAIN_CYCLES = 32;
    localparam int TIMEOUT     = 10_000_000;

    // One expected result word: the average and its status flag.
    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                status;
    } avg_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // [3:0] channel, [13:4] sample, rest zero
    logic [0:0]  s_axis_tuser;    // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;    // [9:0] average, rest zero
    logic [0:0]  m_axis_tuser;    // [0] status

    // Model of the rings: sample memory and both pointers per channel.
    logic [SAMPLE_W-1:0] ring_mem [NUM_CH][RING_DEPTH];
    logic [PTR_W-1:0]    wr_ptr [NUM_CH];
    logic [PTR_W-1:0]    rd_ptr [NUM_CH];

    avg_result_t pending_averages[$];
    int unsigned error_count = 0;

    // When set, neither the sender nor the receiver inserts idle cycles.
    bit no_gaps = 1'b0;

    multichannel_sample_ring_averager_unit #(
        .CHANNELS (NUM_CH),
        .DEPTH    (RING_DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Ring pointer advance with wrap at the ring depth.
    function automatic logic [PTR_W-1:0] ring_step(logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Applies one accepted word to the ring model. A store updates the ring
    // of a valid channel; a read drains the unread slots and queues the
    // result word the block must return.
    function automatic void predict_ring_request(logic req, logic [CHAN_W-1:0] ch,
                                                 logic [SAMPLE_W-1:0] smp);
        avg_result_t      res;
        logic [CH_W-1:0]  ci;
        logic [PTR_W-1:0] rp;
        logic [PTR_W-1:0] newest_slot;
        int unsigned      total;
        int unsigned      count;
        ci = CH_W'(ch);
        if (req == REQ_STORE)
        begin
            // Stores to a channel past the last one are dropped.
            if (ch < NUM_CH)
            begin
                ring_mem[ci][wr_ptr[ci]] = smp;
                wr_ptr[ci] = ring_step(wr_ptr[ci]);
            end
            return;
        end
        if (ch >= NUM_CH)
        begin
            res.average = '0;
            res.status  = STATUS_BAD;
            pending_averages.push_back(res);
            return;
        end
        rp    = rd_ptr[ci];
        total = 0;
        count = 0;
        while (rp != wr_ptr[ci])
        begin
            total += ring_mem[ci][rp];
            count++;
            rp = ring_step(rp);
        end
        rd_ptr[ci] = rp;
        if (count == 0)
        begin
            // Nothing unread, including a full overrun: return the newest sample.
            newest_slot = (wr_ptr[ci] == '0) ? PTR_W'(RING_DEPTH - 1) : wr_ptr[ci] - 1'b1;
            res.average = ring_mem[ci][newest_slot];
        end
        else
        begin
            res.average = SAMPLE_W'(total / count);
        end
        res.status = STATUS_OK;
        pending_averages.push_back(res);
    endfunction

    // Presents one word at a falling edge, after random idle cycles, and
    // holds it until the block takes it at a rising edge. tvalid is left high
    // on return so back-to-back words need no extra assignment.
    task automatic send_word(input logic req, input logic [CHAN_W-1:0] ch,
                             input logic [SAMPLE_W-1:0] smp);
        @(negedge clk);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {2'b00, smp, ch};
        do @(posedge clk); while (!s_axis_tready);
        predict_ring_request(req, ch, smp);
    endtask

    // Receiver: stalls in about IDLE_PCT percent of cycles unless gaps are off.
    always @(negedge clk)
        m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);

    // Every result word taken is checked against the oldest expectation.
    always @(posedge clk)
    begin
        avg_result_t exp_res;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_averages.size() == 0)
            begin
                $error("result word with no read waiting: average %0d status %0d",
                       m_axis_tdata[SAMPLE_W-1:0], m_axis_tuser[0]);
                error_count++;
            end
            else
            begin
                exp_res = pending_averages.pop_front();
                if (m_axis_tdata[SAMPLE_W-1:0] !== exp_res.average)
                begin
                    $error("average mismatch: expected %0d, actual %0d",
                           exp_res.average, m_axis_tdata[SAMPLE_W-1:0]);
                    error_count++;
                end
                if (m_axis_tuser[0] !== exp_res.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           exp_res.status, m_axis_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    // Reads straight after reset see empty rings and must return zero.
    task automatic test_reset_reads();
        send_word(REQ_READ, 4'd0, '0);
        send_word(REQ_READ, 4'(NUM_CH - 1), SAMPLE_MASK);
    endtask

    // Channels past the last one: stores vanish, reads flag an error.
    task automatic test_bad_channel();
        send_word(REQ_STORE, 4'(NUM_CH), 10'h155);
        send_word(REQ_STORE, 4'hF, SAMPLE_MASK);
        send_word(REQ_READ, 4'(NUM_CH), '0);
        send_word(REQ_READ, 4'hF, SAMPLE_MASK);
    endtask

    // Full-scale and zero samples averaged with truncation, then a read
    // with nothing unread, which must return the newest sample.
    task automatic test_mean_extremes();
        send_word(REQ_STORE, 4'd1, SAMPLE_MASK);
        send_word(REQ_STORE, 4'd1, SAMPLE_MASK);
        send_word(REQ_STORE, 4'd1, '0);
        send_word(REQ_READ, 4'd1, '0);
        send_word(REQ_READ, 4'd1, '0);
    endtask

    // A whole ring of unread stores wraps the write pointer onto the read
    // pointer, so the ring looks empty and the newest sample comes back.
    task automatic test_ring_overrun();
        int i;
        for (i = 0; i < RING_DEPTH; i++)
            send_word(REQ_STORE, 4'd2, SAMPLE_W'(i * 97 + 3));
        send_word(REQ_READ, 4'd2, '0);
    endtask

    // Mostly bursts of stores on a valid channel closed by a read, with
    // occasional overrun bursts and random noise words on any channel.
    task automatic test_random_traffic();
        int unsigned      sent;
        int unsigned      burst;
        int unsigned      k;
        logic [CHAN_W-1:0] ch;
        logic             req;
        sent    = 0;
        no_gaps = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= CALM_ITEMS)
                no_gaps = 1'b0;
            if ($urandom_range(0, 99) < 80)
            begin
                ch    = CHAN_W'($urandom_range(0, NUM_CH - 1));
                burst = ($urandom_range(0, 9) == 0) ?
                        $urandom_range(RING_DEPTH, RING_DEPTH + 3) :
                        $urandom_range(0, RING_DEPTH - 1);
                for (k = 0; k < burst; k++)
                begin
                    send_word(REQ_STORE, ch, SAMPLE_W'($urandom_range(0, SAMPLE_MASK)));
                    sent++;
                end
                send_word(REQ_READ, ch, SAMPLE_W'($urandom_range(0, SAMPLE_MASK)));
                sent++;
            end
            else
            begin
                ch  = CHAN_W'($urandom_range(0, 15));
                req = 1'($urandom_range(0, 1));
                send_word(req, ch, SAMPLE_W'($urandom_range(0, SAMPLE_MASK)));
                // A dropped store does nothing, so it is not counted.
                if (!(req == REQ_STORE && ch >= NUM_CH))
                    sent++;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_STORE;
        for (int c = 0; c < NUM_CH; c++)
        begin
            wr_ptr[c] = '0;
            rd_ptr[c] = '0;
            for (int d = 0; d < RING_DEPTH; d++)
                ring_mem[c][d] = '0;
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_reset_reads();
        test_bad_channel();
        test_mean_extremes();
        test_ring_overrun();
        test_random_traffic();

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        no_gaps = 1'b0;
        wait (pending_averages.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_averages.size() == 0)
            $display("PASS multichannel_sample_ring_averager_unit");
        else
            $display("FAIL multichannel_sample_ring_averager_unit");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        #(TIMEOUT);
        $display("FAIL multichannel_sample_ring_averager_unit");
        $finish;
    end

endmodule
